/* hdl/polyphonic_adsr_sample_player_assert.svh */
// assertion macros shared by the checker
`ifndef POLYPHONIC_ADSR_SAMPLE_PLAYER_ASSERT_SVH
`define POLYPHONIC_ADSR_SAMPLE_PLAYER_ASSERT_SVH

// condition holds at every edge
`define PASP_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pasp assertion failed");

// consequent in the same cycle
`define PASP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pasp assertion failed");

// consequent in the next cycle
`define PASP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pasp assertion failed");

`endif

/* hdl/pasp_pkg.sv */
`default_nettype none
package pasp_pkg;

   localparam int NUM_VOICES   = 8;
   localparam int VOICE_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int SAMPLE_DEPTH = 65536;
   localparam int SAMP_AW      = $clog2(SAMPLE_DEPTH);
   localparam int SUM_W        = 18 + VOICE_W;
   localparam int OUT_W        = 19;
   localparam int CMDQ_DEPTH   = 4;
   localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);

   localparam logic [23:0] ENV_ONE   = 24'h800000;
   // floor(2^31 / 127), quotient estimate is low by at most one
   localparam logic [24:0] RECIP_127 = 25'd16909320;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;

   typedef enum logic [2:0] {
      REQ_LOAD        = 3'd0,
      REQ_NOTE_ON     = 3'd1,
      REQ_NOTE_OFF    = 3'd2,
      REQ_RELEASE_ALL = 3'd3,
      REQ_TICK        = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_DECAY   = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CSR_ATTACK    = 3'd0,
      CSR_DECAY     = 3'd1,
      CSR_RELEASE   = 3'd2,
      CSR_SUSTAIN   = 3'd3,
      CSR_REG_START = 3'd4,
      CSR_REG_END   = 3'd5,
      CSR_ROOT      = 3'd6,
      CSR_BASE_INC  = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PITCH,
      ST_EVAL,
      ST_RD0,
      ST_RD1,
      ST_INTERP,
      ST_MUL,
      ST_RECIP,
      ST_ACC,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic [23:0] attack_step;
      logic [23:0] decay_step;
      logic [23:0] release_step;
      logic [23:0] sustain_level;
      logic [15:0] region_start;
      logic [15:0] region_end;
      logic [6:0]  root_note;
      logic [23:0] base_increment;
   } cfg_type;

   typedef struct packed {
      req_code_type       op;
      logic [6:0]         note;
      logic [6:0]         velocity;
      logic [15:0]        address;
      logic signed [15:0] left_value;
      logic signed [15:0] right_value;
   } cmd_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
   } result_type;

   function automatic logic [16:0] semitone(input logic [3:0] s);
      logic [16:0] r;
      case (s)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd69433;
         4'd2:    r = 17'd73562;
         4'd3:    r = 17'd77936;
         4'd4:    r = 17'd82570;
         4'd5:    r = 17'd87480;
         4'd6:    r = 17'd92682;
         4'd7:    r = 17'd98193;
         4'd8:    r = 17'd104032;
         4'd9:    r = 17'd110218;
         4'd10:   r = 17'd116772;
         4'd11:   r = 17'd123715;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] s);
      logic signed [OUT_W-1:0] r;
      if (s > SUM_W'(OUT_MAX)) begin
         r = OUT_MAX;
      end else if (s < SUM_W'(OUT_MIN)) begin
         r = OUT_MIN;
      end else begin
         r = OUT_W'(s);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/pasp_ram.sv */
`default_nettype none
module pasp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

/* hdl/pasp_front.sv */
`default_nettype none
module pasp_front
   import pasp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_type,
   input  wire logic [6:0]         req_note,
   input  wire logic [6:0]         req_velocity,
   input  wire logic [15:0]        req_address,
   input  wire logic signed [15:0] req_left_value,
   input  wire logic signed [15:0] req_right_value,
   output logic                    cmd_valid,
   output cmd_type                 cmd,
   input  wire logic               cmd_pop
);

   cmd_type              q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CMDQ_AW:0]     cnt_ff, cnt_in;
   logic                 known;
   logic                 do_push, do_pop;
   cmd_type              item;

   assign full      = (cnt_ff == (CMDQ_AW + 1)'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   // unknown codes are dropped here and never reach the engine
   assign known   = (req_type <= REQ_TICK);
   assign do_push = push && !full && known;
   assign do_pop  = cmd_pop && cmd_valid;

   always_comb begin
      item.note        = req_note;
      item.velocity    = req_velocity;
      item.address     = req_address;
      item.left_value  = req_left_value;
      item.right_value = req_right_value;
      // note on at zero velocity behaves as note off
      if (req_type == REQ_NOTE_ON && req_velocity == 7'd0) begin
         item.op = REQ_NOTE_OFF;
      end else begin
         item.op = req_code_type'(req_type);
      end
   end

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= item;
      end
   end

endmodule
`default_nettype wire

/* hdl/pasp_back.sv */
`default_nettype none
module pasp_back
   import pasp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire logic                    cmd_valid,
   input  wire cmd_type                 cmd,
   output logic                         cmd_pop,
   input  wire logic                    pop,
   output logic                         empty,
   output logic signed [OUT_W-1:0]      rsp_left_out,
   output logic signed [OUT_W-1:0]      rsp_right_out
);

   back_state_type state_ff, state_in;

   // per-voice state
   logic [NUM_VOICES-1:0] act_ff, act_in;
   logic [6:0]            vnote_ff  [NUM_VOICES];
   logic [6:0]            vnote_in  [NUM_VOICES];
   logic [6:0]            vgain_ff  [NUM_VOICES];
   logic [6:0]            vgain_in  [NUM_VOICES];
   logic [31:0]           vpos_ff   [NUM_VOICES];
   logic [31:0]           vpos_in   [NUM_VOICES];
   logic [23:0]           vstep_ff  [NUM_VOICES];
   logic [23:0]           vstep_in  [NUM_VOICES];
   logic [23:0]           vlvl_ff   [NUM_VOICES];
   logic [23:0]           vlvl_in   [NUM_VOICES];
   phase_type             vphase_ff [NUM_VOICES];
   phase_type             vphase_in [NUM_VOICES];

   // working registers
   cmd_type               cmd_ff, cmd_in;
   logic [VOICE_W-1:0]    cv_ff, cv_in;
   logic [SAMP_AW-1:0]    idx_ff, idx_in;
   logic [15:0]           frac_ff, frac_in;
   logic [23:0]           lvlw_ff, lvlw_in;
   logic [6:0]            gainw_ff, gainw_in;
   logic signed [15:0]    s0l_ff, s0l_in, s0r_ff, s0r_in;
   logic signed [32:0]    pdl_ff, pdl_in, pdr_ff, pdr_in;
   logic [30:0]           lg_ff, lg_in;
   logic [31:0]           avl_ff, avl_in, avr_ff, avr_in;
   logic                  negl_ff, negl_in, negr_ff, negr_in;
   logic [62:0]           ml_ff, ml_in, mr_ff, mr_in;
   logic [23:0]           tl_ff, tl_in, tr_ff, tr_in;
   logic [48:0]           el_ff, el_in, er_ff, er_in;
   logic signed [SUM_W-1:0] suml_ff, suml_in, sumr_ff, sumr_in;
   logic [40:0]           prod_ff, prod_in;
   logic [4:0]            shift_ff, shift_in;

   // result queue
   result_type            res_ff [2];
   logic                  owp_ff, owp_in, orp_ff, orp_in;
   logic [1:0]            ocnt_ff, ocnt_in;
   logic                  opush, opop;
   result_type            res_new;

   // sample memory
   logic                  ram_we;
   logic [SAMP_AW-1:0]    ram_waddr, ram_raddr;
   logic [31:0]           ram_rdata;

   // voice evaluation
   logic [31:0]           e_pos;
   logic [15:0]           e_idx;
   logic [16:0]           e_end;
   logic [23:0]           e_sus;
   logic                  e_ended, e_kill, e_skip;
   logic [23:0]           e_lvl;
   phase_type             e_phase;
   logic [24:0]           e_att;
   logic [24:0]           e_dec_lim;
   logic [32:0]           e_np;
   logic                  last_voice;

   // pitch and voice pick
   logic [8:0]            p_x;
   logic [18:0]           p_q19;
   logic [4:0]            p_q;
   logic [8:0]            p_semi9;
   logic [40:0]           p_sh;
   logic [23:0]           p_step;
   logic [VOICE_W-1:0]    p_sel;

   // division and accumulate
   logic [17:0]           a_q0l, a_q0r;
   logic [24:0]           a_rl, a_rr;
   logic [16:0]           a_ql, a_qr;
   logic signed [SUM_W-1:0] a_cl, a_cr;
   logic signed [16:0]    d_l, d_r;
   logic signed [33:0]    v_l, v_r;
   logic                  in_load;

   pasp_ram #(
      .WIDTH (32),
      .DEPTH (SAMPLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({cmd.right_value, cmd.left_value}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign last_voice = (cv_ff == VOICE_W'(NUM_VOICES - 1));

   // address fits the store; any address that does not is ignored
   assign in_load   = ({1'b0, cmd.address} < 17'(SAMPLE_DEPTH));
   assign ram_waddr = SAMP_AW'(cmd.address);
   assign ram_we    = (state_ff == ST_IDLE) && cmd_valid && (cmd.op == REQ_LOAD) && in_load;

   // envelope step and end checks for the current voice
   always_comb begin
      e_pos     = vpos_ff[cv_ff];
      e_idx     = e_pos[31:16];
      e_end     = (cfg.region_end > cfg.region_start) ? {1'b0, cfg.region_end}
                                                      : {1'b0, cfg.region_start} + 17'd1;
      e_sus     = (cfg.sustain_level > ENV_ONE) ? ENV_ONE : cfg.sustain_level;
      e_ended   = ({1'b0, e_idx} >= 17'(SAMPLE_DEPTH - 1)) || ({1'b0, e_idx} >= e_end);
      e_lvl     = vlvl_ff[cv_ff];
      e_phase   = vphase_ff[cv_ff];
      e_kill    = 1'b0;
      e_att     = {1'b0, vlvl_ff[cv_ff]} + {1'b0, cfg.attack_step};
      e_dec_lim = {1'b0, cfg.decay_step} + {1'b0, e_sus};
      case (vphase_ff[cv_ff])
         PH_ATTACK: begin
            if (e_att >= {1'b0, ENV_ONE}) begin
               e_lvl   = ENV_ONE;
               e_phase = PH_DECAY;
            end else begin
               e_lvl = e_att[23:0];
            end
         end
         PH_DECAY: begin
            if ({1'b0, vlvl_ff[cv_ff]} <= e_dec_lim) begin
               e_lvl   = e_sus;
               e_phase = PH_SUSTAIN;
            end else begin
               e_lvl = vlvl_ff[cv_ff] - cfg.decay_step;
            end
         end
         PH_RELEASE: begin
            if (cfg.release_step >= vlvl_ff[cv_ff]) begin
               e_kill = 1'b1;
               e_lvl  = 24'd0;
            end else begin
               e_lvl = vlvl_ff[cv_ff] - cfg.release_step;
            end
         end
         default: begin
            e_lvl = vlvl_ff[cv_ff];
         end
      endcase
      e_np   = {1'b0, e_pos} + {9'd0, vstep_ff[cv_ff]};
      e_skip = !act_ff[cv_ff] || e_ended || e_kill;
   end

   // pitch: note - root split into octave and semitone through x = d + 132
   always_comb begin
      p_x     = {2'b0, cmd.note} + 9'd132 - {2'b0, cfg.root_note};
      p_q19   = 19'(p_x) * 19'd683;
      p_q     = p_q19[17:13];
      p_semi9 = p_x - 9'(p_q) * 9'd12;
      p_sh    = prod_ff >> shift_ff;
      p_step  = (p_sh[40:24] != '0) ? 24'hFFFFFF : p_sh[23:0];
      p_sel   = '0;
      for (int i = NUM_VOICES - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            p_sel = VOICE_W'(i);
         end
      end
   end

   // divide by 127 with one correction step, then sign
   always_comb begin
      a_q0l = el_ff[48:31];
      a_q0r = er_ff[48:31];
      a_rl  = 25'(tl_ff) - 25'(a_q0l) * 25'd127;
      a_rr  = 25'(tr_ff) - 25'(a_q0r) * 25'd127;
      a_ql  = 17'(a_q0l) + ((a_rl >= 25'd127) ? 17'd1 : 17'd0);
      a_qr  = 17'(a_q0r) + ((a_rr >= 25'd127) ? 17'd1 : 17'd0);
      a_cl  = negl_ff ? -SUM_W'(a_ql) : SUM_W'(a_ql);
      a_cr  = negr_ff ? -SUM_W'(a_qr) : SUM_W'(a_qr);
      d_l   = $signed({ram_rdata[15], ram_rdata[15:0]}) - $signed({s0l_ff[15], s0l_ff});
      d_r   = $signed({ram_rdata[31], ram_rdata[31:16]}) - $signed({s0r_ff[15], s0r_ff});
      v_l   = $signed({{2{s0l_ff[15]}}, s0l_ff, 16'd0}) + 34'(pdl_ff);
      v_r   = $signed({{2{s0r_ff[15]}}, s0r_ff, 16'd0}) + 34'(pdr_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == REQ_NOTE_ON) begin
                  state_in = ST_PITCH;
               end else if (cmd.op == REQ_TICK) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_PITCH:  state_in = ST_IDLE;
         ST_EVAL: begin
            if (!e_skip) begin
               state_in = ST_RD0;
            end else if (last_voice) begin
               state_in = ST_DONE;
            end
         end
         ST_RD0:    state_in = ST_RD1;
         ST_RD1:    state_in = ST_INTERP;
         ST_INTERP: state_in = ST_MUL;
         ST_MUL:    state_in = ST_RECIP;
         ST_RECIP:  state_in = ST_ACC;
         ST_ACC:    state_in = last_voice ? ST_DONE : ST_EVAL;
         ST_DONE: begin
            if (ocnt_ff != 2'd2) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      act_in    = act_ff;
      vnote_in  = vnote_ff;
      vgain_in  = vgain_ff;
      vpos_in   = vpos_ff;
      vstep_in  = vstep_ff;
      vlvl_in   = vlvl_ff;
      vphase_in = vphase_ff;
      cmd_in    = cmd_ff;
      cv_in     = cv_ff;
      idx_in    = idx_ff;
      frac_in   = frac_ff;
      lvlw_in   = lvlw_ff;
      gainw_in  = gainw_ff;
      s0l_in    = s0l_ff;
      s0r_in    = s0r_ff;
      pdl_in    = pdl_ff;
      pdr_in    = pdr_ff;
      lg_in     = lg_ff;
      avl_in    = avl_ff;
      avr_in    = avr_ff;
      negl_in   = negl_ff;
      negr_in   = negr_ff;
      ml_in     = ml_ff;
      mr_in     = mr_ff;
      tl_in     = tl_ff;
      tr_in     = tr_ff;
      el_in     = el_ff;
      er_in     = er_ff;
      suml_in   = suml_ff;
      sumr_in   = sumr_ff;
      prod_in   = prod_ff;
      shift_in  = shift_ff;
      cmd_pop   = 1'b0;
      opush     = 1'b0;
      ram_raddr = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               prod_in  = 41'(cfg.base_increment) * 41'(semitone(p_semi9[3:0]));
               shift_in = 5'd27 - p_q;
               cv_in    = '0;
               suml_in  = '0;
               sumr_in  = '0;
               for (int i = 0; i < NUM_VOICES; i++) begin
                  if (act_ff[i] && ((cmd.op == REQ_RELEASE_ALL) ||
                      (cmd.op == REQ_NOTE_OFF && vnote_ff[i] == cmd.note))) begin
                     vphase_in[i] = PH_RELEASE;
                  end
               end
            end
         end
         ST_PITCH: begin
            act_in[p_sel]    = 1'b1;
            vnote_in[p_sel]  = cmd_ff.note;
            vgain_in[p_sel]  = cmd_ff.velocity;
            vpos_in[p_sel]   = {cfg.region_start, 16'd0};
            vstep_in[p_sel]  = p_step;
            vlvl_in[p_sel]   = 24'd0;
            vphase_in[p_sel] = PH_ATTACK;
         end
         ST_EVAL: begin
            ram_raddr = SAMP_AW'(e_idx);
            if (act_ff[cv_ff]) begin
               if (e_ended) begin
                  act_in[cv_ff] = 1'b0;
               end else if (e_kill) begin
                  act_in[cv_ff]  = 1'b0;
                  vlvl_in[cv_ff] = 24'd0;
               end else begin
                  vlvl_in[cv_ff]   = e_lvl;
                  vphase_in[cv_ff] = e_phase;
                  // a position that would wrap ends the voice after this tick
                  if (e_np[32]) begin
                     act_in[cv_ff] = 1'b0;
                  end else begin
                     vpos_in[cv_ff] = e_np[31:0];
                  end
               end
            end
            idx_in   = SAMP_AW'(e_idx);
            frac_in  = e_pos[15:0];
            lvlw_in  = e_lvl;
            gainw_in = vgain_ff[cv_ff];
            if (e_skip && !last_voice) begin
               cv_in = cv_ff + 1'b1;
            end
         end
         ST_RD0: begin
            ram_raddr = idx_ff + 1'b1;
            s0l_in    = $signed(ram_rdata[15:0]);
            s0r_in    = $signed(ram_rdata[31:16]);
         end
         ST_RD1: begin
            pdl_in = 33'($signed({1'b0, frac_ff}) * d_l);
            pdr_in = 33'($signed({1'b0, frac_ff}) * d_r);
            lg_in  = 31'(lvlw_ff) * 31'(gainw_ff);
         end
         ST_INTERP: begin
            negl_in = v_l[33];
            negr_in = v_r[33];
            avl_in  = v_l[33] ? 32'(-v_l) : 32'(v_l);
            avr_in  = v_r[33] ? 32'(-v_r) : 32'(v_r);
         end
         ST_MUL: begin
            ml_in = 63'(avl_ff) * 63'(lg_ff);
            mr_in = 63'(avr_ff) * 63'(lg_ff);
         end
         ST_RECIP: begin
            tl_in = ml_ff[62:39];
            tr_in = mr_ff[62:39];
            el_in = 49'(ml_ff[62:39]) * 49'(RECIP_127);
            er_in = 49'(mr_ff[62:39]) * 49'(RECIP_127);
         end
         ST_ACC: begin
            suml_in = suml_ff + a_cl;
            sumr_in = sumr_ff + a_cr;
            if (!last_voice) begin
               cv_in = cv_ff + 1'b1;
            end
         end
         ST_DONE: begin
            opush = (ocnt_ff != 2'd2);
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   // result queue
   assign res_new.left  = sat_out(suml_ff);
   assign res_new.right = sat_out(sumr_ff);
   assign empty         = (ocnt_ff == 2'd0);
   assign opop          = pop && !empty;
   assign rsp_left_out  = res_ff[orp_ff].left;
   assign rsp_right_out = res_ff[orp_ff].right;

   always_comb begin
      owp_in  = opush ? !owp_ff : owp_ff;
      orp_in  = opop ? !orp_ff : orp_ff;
      ocnt_in = ocnt_ff;
      if (opush && !opop) begin
         ocnt_in = ocnt_ff + 2'd1;
      end else if (opop && !opush) begin
         ocnt_in = ocnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         owp_ff   <= 1'b0;
         orp_ff   <= 1'b0;
         ocnt_ff  <= 2'd0;
         act_ff   <= '0;
         cv_ff    <= '0;
         for (int i = 0; i < NUM_VOICES; i++) begin
            vnote_ff[i]  <= '0;
            vgain_ff[i]  <= '0;
            vpos_ff[i]   <= '0;
            vstep_ff[i]  <= '0;
            vlvl_ff[i]   <= '0;
            vphase_ff[i] <= PH_ATTACK;
         end
      end else begin
         state_ff  <= state_in;
         owp_ff    <= owp_in;
         orp_ff    <= orp_in;
         ocnt_ff   <= ocnt_in;
         act_ff    <= act_in;
         cv_ff     <= cv_in;
         vnote_ff  <= vnote_in;
         vgain_ff  <= vgain_in;
         vpos_ff   <= vpos_in;
         vstep_ff  <= vstep_in;
         vlvl_ff   <= vlvl_in;
         vphase_ff <= vphase_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      frac_ff  <= frac_in;
      lvlw_ff  <= lvlw_in;
      gainw_ff <= gainw_in;
      s0l_ff   <= s0l_in;
      s0r_ff   <= s0r_in;
      pdl_ff   <= pdl_in;
      pdr_ff   <= pdr_in;
      lg_ff    <= lg_in;
      avl_ff   <= avl_in;
      avr_ff   <= avr_in;
      negl_ff  <= negl_in;
      negr_ff  <= negr_in;
      ml_ff    <= ml_in;
      mr_ff    <= mr_in;
      tl_ff    <= tl_in;
      tr_ff    <= tr_in;
      el_ff    <= el_in;
      er_ff    <= er_in;
      suml_ff  <= suml_in;
      sumr_ff  <= sumr_in;
      prod_ff  <= prod_in;
      shift_ff <= shift_in;
      if (opush) begin
         res_ff[owp_ff] <= res_new;
      end
   end

endmodule
`default_nettype wire

/* hdl/polyphonic_adsr_sample_player.sv */
// Polyphonic sample player: load requests fill a 64K-entry stereo sample memory, note on/off
// and release-all requests start and release up to eight ADSR voices, and each tick request
// returns one saturated left/right mix. Requests enter a four-deep command queue and are
// executed one at a time by the voice engine; load, note off and release all are handled in the
// idle state, note on also passes through a pitch state. A tick walks the voices one at a time
// through a single shared interpolate-and-scale datapath whose two sample reads go through the
// one memory read port.
// The sample memory has no reset or clearing pass; entries read before being loaded are
// unspecified. Configuration registers are read live by the engine.
`default_nettype none
module polyphonic_adsr_sample_player
   import pasp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   output logic                         full,
   input  wire logic [2:0]              req_type,
   input  wire logic [6:0]              req_note,
   input  wire logic [6:0]              req_velocity,
   input  wire logic [15:0]             req_address,
   input  wire logic signed [15:0]      req_left_value,
   input  wire logic signed [15:0]      req_right_value,
   output logic                         empty,
   input  wire logic                    pop,
   output logic signed [OUT_W-1:0]      rsp_left_out,
   output logic signed [OUT_W-1:0]      rsp_right_out,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [4:0]              paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_idx;
   logic          csr_wr;
   logic          cmd_valid, cmd_pop;
   cmd_type       cmd;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_ATTACK:    cfg_in.attack_step    = pwdata[23:0];
            CSR_DECAY:     cfg_in.decay_step     = pwdata[23:0];
            CSR_RELEASE:   cfg_in.release_step   = pwdata[23:0];
            CSR_SUSTAIN:   cfg_in.sustain_level  = pwdata[23:0];
            CSR_REG_START: cfg_in.region_start   = pwdata[15:0];
            CSR_REG_END:   cfg_in.region_end     = pwdata[15:0];
            CSR_ROOT:      cfg_in.root_note      = pwdata[6:0];
            CSR_BASE_INC:  cfg_in.base_increment = pwdata[23:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_ATTACK:    prdata = {8'd0, cfg_ff.attack_step};
         CSR_DECAY:     prdata = {8'd0, cfg_ff.decay_step};
         CSR_RELEASE:   prdata = {8'd0, cfg_ff.release_step};
         CSR_SUSTAIN:   prdata = {8'd0, cfg_ff.sustain_level};
         CSR_REG_START: prdata = {16'd0, cfg_ff.region_start};
         CSR_REG_END:   prdata = {16'd0, cfg_ff.region_end};
         CSR_ROOT:      prdata = {25'd0, cfg_ff.root_note};
         CSR_BASE_INC:  prdata = {8'd0, cfg_ff.base_increment};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_step    <= 24'd8388;
         cfg_ff.decay_step     <= 24'd0;
         cfg_ff.release_step   <= 24'd8388;
         cfg_ff.sustain_level  <= ENV_ONE;
         cfg_ff.region_start   <= 16'd0;
         cfg_ff.region_end     <= 16'd65535;
         cfg_ff.root_note      <= 7'd60;
         cfg_ff.base_increment <= 24'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pasp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_note        (req_note),
      .req_velocity    (req_velocity),
      .req_address     (req_address),
      .req_left_value  (req_left_value),
      .req_right_value (req_right_value),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   pasp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .pop           (pop),
      .empty         (empty),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule
`default_nettype wire

/* hdl/pasp_checker.sv */
`default_nettype none
`include "polyphonic_adsr_sample_player_assert.svh"
module pasp_checker
   import pasp_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               push,
   input wire logic               full,
   input wire logic               empty,
   input wire logic               pop,
   input wire logic signed [18:0] rsp_left_out,
   input wire logic signed [18:0] rsp_right_out,
   input wire logic               psel,
   input wire logic               pwrite,
   input wire logic [4:0]         paddr,
   input wire logic [31:0]        prdata,
   input wire logic               pready
);

   // no wait states on the register port
   `PASP_ASSERT_ALWAYS(a_pready_high, clock, reset, pready)

   // both queues come out of reset drained
   `PASP_ASSERT_NEXT(a_reset_clean, clock, 1'b0, reset, empty && !full)

   // the command queue only fills through pushes
   `PASP_ASSERT_NEXT(a_full_needs_push, clock, reset, !full && !push, !full)

   // a waiting result stays put until taken
   `PASP_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop,
                     !empty && $stable(rsp_left_out) && $stable(rsp_right_out))

   // root note reads back as a 7-bit value
   `PASP_ASSERT_IMPL(a_root_read, clock, reset, psel && !pwrite && paddr[4:2] == CSR_ROOT,
                     prdata[31:7] == 25'd0)

endmodule

bind polyphonic_adsr_sample_player pasp_checker u_checker (.*);
`default_nettype wire

/* dv/tb_polyphonic_adsr_sample_player.sv */
`default_nettype none
module tb_polyphonic_adsr_sample_player;
   timeunit 1ns;
   timeprecision 1ps;
   import pasp_pkg::*;

   typedef struct {
      logic [2:0]         kind;
      logic [6:0]         note;
      logic [6:0]         vel;
      logic [15:0]        addr;
      logic signed [15:0] lv;
      logic signed [15:0] rv;
   } voice_req_type;

   typedef struct {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
   } mix_type;

   localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
   localparam int unsigned LOW_WIN_TOP = 63;
   localparam int unsigned HIGH_WIN_BASE = 65472;
   localparam int unsigned SEMI_RATIO [12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                               92682, 98193, 104032, 110218, 116772, 123715};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [2:0] req_type = '0;
   logic [6:0] req_note = '0;
   logic [6:0] req_velocity = '0;
   logic [15:0] req_address = '0;
   logic signed [15:0] req_left_value = '0;
   logic signed [15:0] req_right_value = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [OUT_W-1:0] rsp_left_out;
   logic signed [OUT_W-1:0] rsp_right_out;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   polyphonic_adsr_sample_player uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_type(req_type), .req_note(req_note), .req_velocity(req_velocity),
      .req_address(req_address), .req_left_value(req_left_value),
      .req_right_value(req_right_value), .empty(empty), .pop(pop),
      .rsp_left_out(rsp_left_out), .rsp_right_out(rsp_right_out),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // shadow of the player state
   cfg_type            cfg;
   bit [31:0]          samp_mem [65536];
   bit                 v_active [NUM_VOICES];
   bit [6:0]           v_note [NUM_VOICES];
   bit [6:0]           v_gain [NUM_VOICES];
   bit [31:0]          v_pos [NUM_VOICES];
   bit [23:0]          v_step [NUM_VOICES];
   bit [23:0]          v_level [NUM_VOICES];
   phase_type          v_phase [NUM_VOICES];

   voice_req_type pend_reqs[$];
   mix_type       mix_expected[$];
   int            err_count = 0;
   int            send_gap = 0;
   int            pop_stall = 0;
   bit            quiet = 1'b0;
   logic [6:0]    recent_notes[$];

   function automatic bit [23:0] note_step(input int n);
      int d, oct, semi;
      longint unsigned prod, s;
      d = n - int'(cfg.root_note);
      oct = (d >= 0) ? d / 12 : -((11 - d) / 12);
      semi = d - 12 * oct;
      prod = longint'(cfg.base_increment) * SEMI_RATIO[semi];
      s = prod >> (16 - oct);
      return (s > 64'hFFFFFF) ? 24'hFFFFFF : s[23:0];
   endfunction

   function automatic void release_notes(input bit all, input logic [6:0] n);
      for (int i = 0; i < NUM_VOICES; i++)
         if (v_active[i] && (all || v_note[i] == n)) v_phase[i] = PH_RELEASE;
   endfunction

   function automatic logic signed [OUT_W-1:0] clip(input longint s);
      if (s > 262143) return OUT_MAX;
      if (s < -262144) return OUT_MIN;
      return s[OUT_W-1:0];
   endfunction

   function automatic mix_type mix_tick();
      longint sl, sr, v, den, np;
      int unsigned pos, idx, frac, endi, sus, lvl;
      bit [31:0] w0, w1;
      mix_type m;
      sl = 0;
      sr = 0;
      den = longint'(127) << 39;
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (!v_active[i]) continue;
         pos = v_pos[i];
         idx = pos >> 16;
         frac = pos & 32'hFFFF;
         endi = (cfg.region_end > cfg.region_start) ? cfg.region_end : cfg.region_start + 1;
         sus = (cfg.sustain_level > ENV_ONE) ? ENV_ONE : cfg.sustain_level;
         lvl = v_level[i];
         if (idx >= 65535 || idx >= endi) begin
            v_active[i] = 0;
            continue;
         end
         case (v_phase[i])
            PH_ATTACK: begin
               lvl = lvl + cfg.attack_step;
               if (lvl >= ENV_ONE) begin
                  lvl = ENV_ONE;
                  v_phase[i] = PH_DECAY;
               end
            end
            PH_DECAY: begin
               if (longint'(lvl) - longint'(cfg.decay_step) <= longint'(sus)) begin
                  lvl = sus;
                  v_phase[i] = PH_SUSTAIN;
               end else begin
                  lvl = lvl - cfg.decay_step;
               end
            end
            PH_RELEASE: begin
               if (cfg.release_step >= lvl) begin
                  v_level[i] = 0;
                  v_active[i] = 0;
                  continue;
               end
               lvl = lvl - cfg.release_step;
            end
            default: ;
         endcase
         v_level[i] = lvl;
         w0 = samp_mem[idx];
         w1 = samp_mem[idx + 1];
         v = longint'($signed(w0[15:0])) * 65536 + longint'(frac) *
             (longint'($signed(w1[15:0])) - longint'($signed(w0[15:0])));
         sl += v * longint'(v_gain[i]) * longint'(lvl) / den;
         v = longint'($signed(w0[31:16])) * 65536 + longint'(frac) *
             (longint'($signed(w1[31:16])) - longint'($signed(w0[31:16])));
         sr += v * longint'(v_gain[i]) * longint'(lvl) / den;
         np = longint'(pos) + longint'(v_step[i]);
         if (np > 64'hFFFFFFFF) v_active[i] = 0;
         else v_pos[i] = np[31:0];
      end
      m.left = clip(sl);
      m.right = clip(sr);
      return m;
   endfunction

   function automatic void apply_request(input voice_req_type r);
      int sel;
      case (r.kind)
         REQ_LOAD: samp_mem[r.addr] = {r.rv, r.lv};
         REQ_NOTE_ON: begin
            if (r.vel == 0) begin
               release_notes(1'b0, r.note);
            end else begin
               sel = 0;
               for (int i = NUM_VOICES - 1; i >= 0; i--)
                  if (!v_active[i]) sel = i;
               v_active[sel] = 1;
               v_note[sel] = r.note;
               v_gain[sel] = r.vel;
               v_pos[sel] = {cfg.region_start, 16'h0000};
               v_step[sel] = note_step(r.note);
               v_level[sel] = 0;
               v_phase[sel] = PH_ATTACK;
            end
         end
         REQ_NOTE_OFF: release_notes(1'b0, r.note);
         REQ_RELEASE_ALL: release_notes(1'b1, 7'd0);
         REQ_TICK: mix_expected.insert(mix_expected.size(), mix_tick());
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      voice_req_type it;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (pend_reqs.size() > 0) begin
            it = pend_reqs.pop_front();
            req_type <= it.kind;
            req_note <= it.note;
            req_velocity <= it.vel;
            req_address <= it.addr;
            req_left_value <= it.lv;
            req_right_value <= it.rv;
            push <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 10);
         end else begin
            push <= 1'b0;
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_stall > 0) begin
         pop_stall--;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) pop_stall = $urandom_range(1, 10);
      end
   end

   // monitor
   always @(posedge clock) begin
      voice_req_type r;
      mix_type e;
      if (!reset) begin
         if (push && !full) begin
            r.kind = req_type;
            r.note = req_note;
            r.vel = req_velocity;
            r.addr = req_address;
            r.lv = req_left_value;
            r.rv = req_right_value;
            apply_request(r);
         end
         if (pop && !empty) begin
            if (mix_expected.size() == 0) begin
               $display("%0t: unexpected transaction left %0d right %0d",
                        $realtime, rsp_left_out, rsp_right_out);
               err_count++;
            end else begin
               e = mix_expected.pop_front();
               if (rsp_left_out !== e.left) begin
                  $display("%0t: left_out expected %0d actual %0d", $realtime, e.left,
                           rsp_left_out);
                  err_count++;
               end
               if (rsp_right_out !== e.right) begin
                  $display("%0t: right_out expected %0d actual %0d", $realtime, e.right,
                           rsp_right_out);
                  err_count++;
               end
            end
         end
      end
   end

   task automatic queue_req(input logic [2:0] k, input logic [6:0] n, input logic [6:0] vl,
                            input logic [15:0] a, input logic [15:0] l, input logic [15:0] rr);
      voice_req_type it;
      it.kind = k;
      it.note = n;
      it.vel = vl;
      it.addr = a;
      it.lv = l;
      it.rv = rr;
      pend_reqs.insert(pend_reqs.size(), it);
   endtask

   task automatic drain();
      while (pend_reqs.size() > 0 || push) @(posedge clock);
      while (mix_expected.size() > 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_ATTACK:    cfg.attack_step = val[23:0];
         CSR_DECAY:     cfg.decay_step = val[23:0];
         CSR_RELEASE:   cfg.release_step = val[23:0];
         CSR_SUSTAIN:   cfg.sustain_level = val[23:0];
         CSR_REG_START: cfg.region_start = val[15:0];
         CSR_REG_END:   cfg.region_end = val[15:0];
         CSR_ROOT:      cfg.root_note = val[6:0];
         default:       cfg.base_increment = val[23:0];
      endcase
   endtask

   // every voice leaves through release before the region moves, so no read strays
   // outside the loaded windows
   task automatic silence_voices();
      csr_write(CSR_RELEASE, ENV_ONE);
      queue_req(REQ_RELEASE_ALL, 0, 0, 0, 0, 0);
      queue_req(REQ_TICK, 0, 0, 0, 0, 0);
      drain();
   endtask

   task automatic set_regs(input logic [23:0] atk, input logic [23:0] dec,
                           input logic [23:0] rel, input logic [23:0] sus,
                           input logic [15:0] st, input logic [15:0] en,
                           input logic [6:0] root, input logic [23:0] base);
      silence_voices();
      csr_write(CSR_ATTACK, atk);
      csr_write(CSR_DECAY, dec);
      csr_write(CSR_RELEASE, rel);
      csr_write(CSR_SUSTAIN, sus);
      csr_write(CSR_REG_START, st);
      csr_write(CSR_REG_END, en);
      csr_write(CSR_ROOT, root);
      csr_write(CSR_BASE_INC, base);
   endtask

   function automatic logic [23:0] rand_env();
      case ($urandom_range(0, 3))
         0:       return 24'($urandom_range(1, 24'h800000));
         1:       return 24'($urandom_range(24'h1000, 24'h100000));
         default: return 24'($urandom_range(1, 24'h20000));
      endcase
   endfunction

   task automatic gen_random(input int n);
      int sel;
      logic [6:0] nt;
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            queue_req(REQ_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else if (sel < 70) begin
            nt = $urandom;
            recent_notes.insert(recent_notes.size(), nt);
            if (recent_notes.size() > 8) void'(recent_notes.pop_front());
            queue_req(REQ_NOTE_ON, nt, ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom),
                      $urandom, $urandom, $urandom);
         end else if (sel < 80) begin
            nt = (recent_notes.size() > 0 && $urandom_range(0, 3) != 0) ?
                 recent_notes[$urandom_range(0, recent_notes.size() - 1)] : 7'($urandom);
            queue_req(REQ_NOTE_OFF, nt, $urandom, $urandom, $urandom, $urandom);
         end else if (sel < 84) begin
            queue_req(REQ_RELEASE_ALL, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else if (sel < 97) begin
            queue_req(REQ_LOAD, $urandom, $urandom,
                      ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63)),
                      $urandom, $urandom);
         end else begin
            queue_req(REQ_FIRST_UNUSED + 3'($urandom_range(0, 2)), $urandom, $urandom,
                      $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      logic [15:0] st, en;
      cfg = '{attack_step: 24'd8388, decay_step: 24'd0, release_step: 24'd8388,
              sustain_level: ENV_ONE, region_start: 16'd0, region_end: 16'd65535,
              root_note: 7'd60, base_increment: 24'd65536};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill both sample windows, extremes first
      queue_req(REQ_LOAD, 0, 0, 0, 16'h7FFF, 16'h8000);
      queue_req(REQ_LOAD, 0, 0, 1, 16'h8000, 16'h7FFF);
      for (int a = 2; a <= LOW_WIN_TOP; a++) queue_req(REQ_LOAD, 0, 0, a, $urandom, $urandom);
      for (int a = HIGH_WIN_BASE; a <= 65535; a++)
         queue_req(REQ_LOAD, 0, 0, a, $urandom, $urandom);
      drain();

      set_regs(24'h100000, 24'h40000, 24'h80000, 24'h400000, 0, 62, 60, 24'd65536);
      queue_req(REQ_NOTE_ON, 60, 127, 0, 0, 0);
      repeat (3) queue_req(REQ_TICK, 0, 0, 0, 0, 0);
      queue_req(REQ_NOTE_ON, 127, 1, 0, 0, 0);
      queue_req(REQ_NOTE_ON, 0, 64, 0, 0, 0);
      repeat (2) queue_req(REQ_TICK, 0, 0, 0, 0, 0);
      queue_req(REQ_NOTE_ON, 60, 0, 0, 0, 0);
      queue_req(REQ_TICK, 0, 0, 0, 0, 0);
      queue_req(REQ_NOTE_OFF, 127, 0, 0, 0, 0);
      queue_req(REQ_TICK, 0, 0, 0, 0, 0);
      queue_req(REQ_FIRST_UNUSED + 3'd2, 7'h7F, 7'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 7; i++) queue_req(REQ_NOTE_ON, 20 + 9 * i, 100, 0, 0, 0);
      repeat (2) queue_req(REQ_TICK, 0, 0, 0, 0, 0);
      queue_req(REQ_RELEASE_ALL, 0, 0, 0, 0, 0);
      repeat (2) queue_req(REQ_TICK, 0, 0, 0, 0, 0);
      gen_random(60);
      drain();

      // top of memory, fastest envelope, largest increment, position overflow
      set_regs(ENV_ONE, 0, ENV_ONE, 24'hFFFFFF, HIGH_WIN_BASE, 65535, 0, 24'hFFFFFF);
      gen_random(100);
      drain();
      // end not above start, zero attack and release
      set_regs(0, ENV_ONE, 0, 0, 40, 40, 127, 1);
      gen_random(80);
      drain();
      // start at the last index, no voice can play
      set_regs(1, 1, 1, 24'h7FFFFF, 65535, 0, 64, 24'h8000);
      gen_random(40);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         if ($urandom_range(0, 2) == 0) begin
            st = $urandom_range(HIGH_WIN_BASE, 65535);
            en = $urandom_range(HIGH_WIN_BASE, 65535);
         end else begin
            st = $urandom_range(0, 50);
            en = $urandom_range(0, 62);
         end
         if (ph == 8) quiet = 1'b1;
         set_regs(rand_env(), ($urandom_range(0, 4) == 0) ? 24'd0 : rand_env(), rand_env(),
                  $urandom_range(0, 24'hFFFFFF), st, en, $urandom_range(0, 127),
                  ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 24'hFFFFFF)) :
                                                24'($urandom_range(1, 24'h30000)));
         gen_random(125);
         drain();
      end

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire
